// ===== hdl/rgbyc_pkg.sv =====
// Package for the RGB to YCbCr 4:2:0 converter: widths, plane codes,
// Q16 coefficients and the state and request types. Depends on nothing.
package rgbyc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = 13;
  localparam int PIX_W      = 8;
  localparam int PAIR_W     = PIX_W + 1;
  localparam int QUAD_W     = PIX_W + 2;
  localparam int LINE_W     = 3 * PAIR_W;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = COEF_W + QUAD_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_W     = 16;

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(1920);
  localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);

  localparam logic [COEF_W-1:0] K_Y_R  = 16'd11966;
  localparam logic [COEF_W-1:0] K_Y_G  = 16'd40253;
  localparam logic [COEF_W-1:0] K_Y_B  = 16'd4064;
  localparam logic [COEF_W-1:0] K_CB_R = 16'd1649;
  localparam logic [COEF_W-1:0] K_CB_G = 16'd5547;
  localparam logic [COEF_W-1:0] K_CB_B = 16'd7196;
  localparam logic [COEF_W-1:0] K_CR_R = 16'd7196;
  localparam logic [COEF_W-1:0] K_CR_G = 16'd6536;
  localparam logic [COEF_W-1:0] K_CR_B = 16'd660;

  localparam logic [ACC_W-1:0] Y_OFFSET = ACC_W'((16 << FRAC_W) + (1 << (FRAC_W - 1)));
  localparam logic [ACC_W-1:0] C_OFFSET = ACC_W'((128 << FRAC_W) + (1 << (FRAC_W - 1)));

  typedef enum logic [1:0] {
    PLANE_Y  = 2'd0,
    PLANE_CB = 2'd1,
    PLANE_CR = 2'd2
  } plane_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    plane_t            plane;
    logic [QUAD_W-1:0] x_r;
    logic [QUAD_W-1:0] x_g;
    logic [QUAD_W-1:0] x_b;
  } dot_req_t;

endpackage

// ===== hdl/rgbyc_line_ram.sv =====
// Single-port synchronous RAM with registered read data, used as the
// line buffer of pair sums. Generic; depends on nothing.
module rgbyc_line_ram #(
  parameter int DATA_W = 27,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/rgbyc_dot.sv =====
// Three-term Q16 weighted sum: registered products, then offset, signed
// combination, rounding and clamp to a byte. Depends on rgbyc_pkg.
module rgbyc_dot import rgbyc_pkg::*; (
  input  logic       clk,
  input  logic       load,
  input  dot_req_t   req,
  output logic [7:0] code
);

  logic [COEF_W-1:0] k_r, k_g, k_b;
  logic [PROD_W-1:0] p_r_r, p_g_r, p_b_r;
  plane_t            plane_r;
  logic [ACC_W-1:0]  e_r, e_g, e_b;
  logic [ACC_W-1:0]  acc;

  always_comb begin
    unique case (req.plane)
      PLANE_Y: begin
        k_r = K_Y_R;
        k_g = K_Y_G;
        k_b = K_Y_B;
      end
      PLANE_CB: begin
        k_r = K_CB_R;
        k_g = K_CB_G;
        k_b = K_CB_B;
      end
      PLANE_CR: begin
        k_r = K_CR_R;
        k_g = K_CR_G;
        k_b = K_CR_B;
      end
      default: begin
        k_r = '0;
        k_g = '0;
        k_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_r_r   <= PROD_W'(k_r) * PROD_W'(req.x_r);
      p_g_r   <= PROD_W'(k_g) * PROD_W'(req.x_g);
      p_b_r   <= PROD_W'(k_b) * PROD_W'(req.x_b);
      plane_r <= req.plane;
    end
  end

  assign e_r = ACC_W'(p_r_r);
  assign e_g = ACC_W'(p_g_r);
  assign e_b = ACC_W'(p_b_r);

  always_comb begin
    unique case (plane_r)
      PLANE_Y:  acc = Y_OFFSET + e_r + e_g + e_b;
      PLANE_CB: acc = C_OFFSET + e_b - e_r - e_g;
      PLANE_CR: acc = C_OFFSET + e_r - e_g - e_b;
      default:  acc = '0;
    endcase
  end

  assign code = (acc[ACC_W-1:FRAC_W+8] != '0) ? 8'hFF : acc[FRAC_W+7:FRAC_W];

endmodule

// ===== hdl/rgb_to_ycbcr_420_converter_unit.sv =====
// Timing: a pixel's luma beat passes through the multiplier state, the registered
// products and a one-entry output register; Cb and Cr follow the same path in turn.
// A new pixel beat is taken only after the last beat of the previous pixel is loaded,
// set by the shared multiplier unit, the one-item sequencer and output back-pressure.
// Reset (synchronous, rst_n low): position, row parity, left pixel and width
// return to their defaults; the line buffer is not cleared.
module rgb_to_ycbcr_420_converter_unit import rgbyc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_frame_width,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic             in_frame_start,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_plane,
  output logic [7:0]       out_sample_value,
  output logic             out_run_last
);

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   frame_width_r, frame_width_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               odd_r, odd_nxt;
  logic [3*PIX_W-1:0] hold_r, hold_nxt;
  plane_t             plane_r, plane_nxt;
  logic               chroma_r;
  logic [PIX_W-1:0]   red_r, green_r, blue_r;
  logic [LINE_W-1:0]  pair_r;
  logic [QUAD_W-1:0]  q_r_r, q_g_r, q_b_r;
  logic               out_valid_r, out_valid_nxt;
  plane_t             out_plane_r;
  logic [7:0]         out_value_r;
  logic               out_last_r;

  logic               accept, out_free, out_load, dot_load, last_beat;
  logic [CFG_W-1:0]   eff_w, col_inc;
  logic [COL_W-1:0]   cur_col;
  logic               cur_odd;
  logic [PAIR_W-1:0]  pr, pg, pb;
  logic               ram_we, ram_re;
  logic [LINE_W-1:0]  ram_q;
  dot_req_t           dot_req;
  logic [7:0]         dot_code;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign last_beat = (plane_r == PLANE_CR) | ((plane_r == PLANE_Y) & ~chroma_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = last_beat ? ST_IDLE : ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    dot_load = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL:  dot_load = 1'b1;
      ST_EMIT: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    if (frame_width_r < WIDTH_MIN) begin
      eff_w = WIDTH_MIN;
    end else if (frame_width_r > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = frame_width_r;
    end
  end

  assign cur_col = in_frame_start ? '0 : col_r;
  assign cur_odd = in_frame_start ? 1'b0 : odd_r;
  assign col_inc = CFG_W'(cur_col) + CFG_W'(1);

  assign pr = PAIR_W'(in_red) + PAIR_W'(hold_r[3*PIX_W-1:2*PIX_W]);
  assign pg = PAIR_W'(in_green) + PAIR_W'(hold_r[2*PIX_W-1:PIX_W]);
  assign pb = PAIR_W'(in_blue) + PAIR_W'(hold_r[PIX_W-1:0]);

  assign ram_we = accept & cur_col[0] & ~cur_odd;
  assign ram_re = accept & cur_col[0] & cur_odd;

  always_comb begin
    frame_width_nxt = cfg_valid ? cfg_frame_width : frame_width_r;
    col_nxt         = col_r;
    odd_nxt         = odd_r;
    hold_nxt        = hold_r;
    plane_nxt       = plane_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    if (accept) begin
      plane_nxt = PLANE_Y;
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        odd_nxt = ~cur_odd;
      end else begin
        col_nxt = col_inc[COL_W-1:0];
        odd_nxt = cur_odd;
      end
      if (!cur_col[0]) begin
        hold_nxt = {in_red, in_green, in_blue};
      end
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      plane_nxt     = (plane_r == PLANE_Y) ? PLANE_CB : PLANE_CR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_width_r <= WIDTH_RESET;
      col_r         <= '0;
      odd_r         <= 1'b0;
      hold_r        <= '0;
      plane_r       <= PLANE_Y;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frame_width_r <= frame_width_nxt;
      col_r         <= col_nxt;
      odd_r         <= odd_nxt;
      hold_r        <= hold_nxt;
      plane_r       <= plane_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_r    <= in_red;
      green_r  <= in_green;
      blue_r   <= in_blue;
      pair_r   <= {pr, pg, pb};
      chroma_r <= cur_col[0] & cur_odd;
    end
    if (dot_load && plane_r == PLANE_Y) begin
      q_r_r <= QUAD_W'(pair_r[3*PAIR_W-1:2*PAIR_W]) + QUAD_W'(ram_q[3*PAIR_W-1:2*PAIR_W]);
      q_g_r <= QUAD_W'(pair_r[2*PAIR_W-1:PAIR_W]) + QUAD_W'(ram_q[2*PAIR_W-1:PAIR_W]);
      q_b_r <= QUAD_W'(pair_r[PAIR_W-1:0]) + QUAD_W'(ram_q[PAIR_W-1:0]);
    end
    if (out_load) begin
      out_plane_r <= plane_r;
      out_value_r <= dot_code;
      out_last_r  <= last_beat;
    end
  end

  always_comb begin
    dot_req.plane = plane_r;
    if (plane_r == PLANE_Y) begin
      dot_req.x_r = QUAD_W'(red_r);
      dot_req.x_g = QUAD_W'(green_r);
      dot_req.x_b = QUAD_W'(blue_r);
    end else begin
      dot_req.x_r = q_r_r;
      dot_req.x_g = q_g_r;
      dot_req.x_b = q_b_r;
    end
  end

  rgbyc_line_ram #(
    .DATA_W (LINE_W),
    .DEPTH  (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (cur_col[COL_W-1:1]),
    .wdata ({pr, pg, pb}),
    .rdata (ram_q)
  );

  rgbyc_dot u_dot (
    .clk  (clk),
    .load (dot_load),
    .req  (dot_req),
    .code (dot_code)
  );

  assign out_valid        = out_valid_r;
  assign out_plane        = out_plane_r;
  assign out_sample_value = out_value_r;
  assign out_run_last     = out_last_r;

endmodule

// ===== hdl/rgbyc_checker.sv =====
// Port-level checker for the RGB to YCbCr 4:2:0 converter, bound to the
// top level. Depends on rgbyc_pkg.
module rgbyc_checker import rgbyc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_plane,
  input logic [7:0] out_sample_value,
  input logic       out_run_last
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_plane)
      && $stable(out_sample_value) && $stable(out_run_last))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second pixel beat taken before the first was processed");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_plane == PLANE_CB) && !out_run_last)
      || ((out_plane == PLANE_CR) && out_run_last) || (out_plane == PLANE_Y))
    else $error("run_last does not match the plane");

  a_chroma_after_luma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_plane == PLANE_Y) && !out_run_last
      |=> !in_ready)
    else $error("pixel beat taken while its chroma is outstanding");

endmodule

bind rgb_to_ycbcr_420_converter_unit rgbyc_checker u_rgbyc_checker (.*);

// ===== tb/sv/rgb_to_ycbcr_420_converter_unit_test.sv =====
// Self-checking testbench for rgb_to_ycbcr_420_converter_unit. A scoreboard predicts the
// luma and 4:2:0 chroma beats of every accepted pixel and checks each result beat in order.
// Depends on rgbyc_pkg and the converter RTL only.
module rgb_to_ycbcr_420_converter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbyc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOWN_ERRORS = 10;
  localparam int SLOTS        = (MAX_WIDTH + 1) / 2;

  localparam int unsigned LUMA_BASE   = (16 << 16) + (1 << 15);
  localparam int unsigned CHROMA_BASE = (128 << 16) + (1 << 15);

  typedef struct {
    plane_t     plane;
    logic [7:0] code;
    logic       last;
  } sample_t;

  class ycbcr_scoreboard;
    logic [26:0] pair_sums [SLOTS];
    bit          pair_written [SLOTS];
    logic [23:0] left_pixel;
    int unsigned column;
    bit          odd_row;
    int unsigned frame_width;
    sample_t     pending_samples [$];
    int          errors;
    int          beats_checked;
    int          pixels;
    int          chroma_blocks;

    function new();
      foreach (pair_sums[i]) begin
        pair_sums[i] = '0;
        pair_written[i] = 1'b0;
      end
      left_pixel = '0;
      column = 0;
      odd_row = 1'b0;
      frame_width = 1920;
      errors = 0;
      beats_checked = 0;
      pixels = 0;
      chroma_blocks = 0;
    endfunction

    function void set_width(logic [CFG_W-1:0] value);
      frame_width = value;
    endfunction

    function int outstanding();
      return pending_samples.size();
    endfunction

    function logic [7:0] to_code(int unsigned acc);
      int unsigned v;
      v = acc >> 16;
      return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // The right pixel of a pair on an odd row reads the pair sums stored above it.
    function bit reads_blank_slot();
      return odd_row && (column % 2 == 1) && !pair_written[column >> 1];
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic restart);
      int unsigned w, slot, pr, pg, pb, r4, g4, b4;
      logic [26:0] above;
      sample_t     s;
      w = frame_width;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (restart) begin
        column = 0;
        odd_row = 1'b0;
      end
      slot = column >> 1;
      pixels++;
      s.plane = PLANE_Y;
      s.code = to_code(LUMA_BASE + 11966 * r + 40253 * g + 4064 * b);
      s.last = 1'b1;
      if (column % 2 == 0) begin
        left_pixel = {r, g, b};
        pending_samples.push_back(s);
      end else begin
        pr = r + left_pixel[23:16];
        pg = g + left_pixel[15:8];
        pb = b + left_pixel[7:0];
        if (!odd_row) begin
          pair_sums[slot] = {pr[8:0], pg[8:0], pb[8:0]};
          pair_written[slot] = 1'b1;
          pending_samples.push_back(s);
        end else begin
          above = pair_written[slot] ? pair_sums[slot] : '0;
          r4 = pr + above[26:18];
          g4 = pg + above[17:9];
          b4 = pb + above[8:0];
          s.last = 1'b0;
          pending_samples.push_back(s);
          s.plane = PLANE_CB;
          s.code = to_code(CHROMA_BASE + 7196 * b4 - 1649 * r4 - 5547 * g4);
          pending_samples.push_back(s);
          s.plane = PLANE_CR;
          s.code = to_code(CHROMA_BASE + 7196 * r4 - 6536 * g4 - 660 * b4);
          s.last = 1'b1;
          pending_samples.push_back(s);
          chroma_blocks++;
        end
      end
      if (column + 1 >= w) begin
        column = 0;
        odd_row = !odd_row;
      end else begin
        column = column + 1;
      end
    endfunction

    function void check_sample(logic [1:0] plane, logic [7:0] code, logic last);
      sample_t e;
      beats_checked++;
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("unexpected result beat: plane %0d value %0d last %0d", plane, code, last);
      end else begin
        e = pending_samples.pop_front();
        if (plane !== e.plane || code !== e.code || last !== e.last) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("result beat %0d: expected plane %0d value %0d last %0d, %s %0d %0d %0d",
                     beats_checked, e.plane, e.code, e.last, "got", plane, code, last);
        end
      end
    endfunction

    function void close();
      if (pending_samples.size() != 0) begin
        errors++;
        $display("%0d expected result beats never arrived", pending_samples.size());
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_frame_width = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_red = '0;
  logic [7:0]       in_green = '0;
  logic [7:0]       in_blue = '0;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_plane;
  logic [7:0]       out_sample_value;
  logic             out_run_last;

  int send_idle_pct = 29;
  int recv_idle_pct = 79;
  int width_writes = 0;
  int cycle_count = 0;
  ycbcr_scoreboard board;

  rgb_to_ycbcr_420_converter_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_frame_width  (cfg_frame_width),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plane        (out_plane),
    .out_sample_value (out_sample_value),
    .out_run_last     (out_run_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_width(cfg_frame_width);
      if (in_valid && in_ready) board.note_pixel(in_red, in_green, in_blue, in_frame_start);
      if (out_valid && out_ready) board.check_sample(out_plane, out_sample_value, out_run_last);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", CYCLE_LIMIT);
      $display("rgb_to_ycbcr_420_converter_unit_test: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return CFG_W'(2 * $urandom_range(1, 6));
      6: return CFG_W'(2 * $urandom_range(1, 5) + 1);
      7: return CFG_W'($urandom_range(1));
      8: return CFG_W'($urandom_range(4097, 8191));
      default: return CFG_W'(4096);
    endcase
  endfunction

  // A frame start is forced where the pixel would otherwise read a line buffer
  // entry that has not been written since reset.
  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic restart);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_frame_start <= restart | board.reads_blank_slot();
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_run(input int count, input bit restart, input int noise_pct);
    for (int i = 0; i < count; i++)
      push_pixel(rand_chan(), rand_chan(), rand_chan(),
                 (i == 0) ? restart : ($urandom_range(99) < noise_pct));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_frame_width <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    width_writes++;
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_width(CFG_W'(4));
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    drain();
    write_width(CFG_W'(2));
    push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    push_pixel(8'd127, 8'd127, 8'd127, 1'b0);
    push_pixel(8'd1, 8'd2, 8'd254, 1'b0);
    drain();
    write_width(CFG_W'(3));
    send_run(6, 1'b1, 0);
    drain();
    write_width(CFG_W'(0));
    send_run(4, 1'b1, 0);
    drain();
    write_width('1);
    send_run(3, 1'b1, 0);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 79 : 0;
      recv_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 29 : 0;
      for (int k = 0; k < 3; k++) begin
        drain();
        write_width(pick_width());
        send_run($urandom_range(10, 18), $urandom_range(3) != 0, 5);
      end
    end
    drain();

    board.close();
    $display("Checked %0d result beats from %0d pixels (%0d chroma blocks), %0d width writes.",
             board.beats_checked, board.pixels, board.chroma_blocks, width_writes);
    if (board.errors == 0) begin
      $display("rgb_to_ycbcr_420_converter_unit_test: done, clean");
    end else begin
      $display("%0d failures in total", board.errors);
      $display("rgb_to_ycbcr_420_converter_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== rgb_to_ycbcr_420_converter_unit.f =====
hdl/rgbyc_pkg.sv
hdl/rgbyc_line_ram.sv
hdl/rgbyc_dot.sv
hdl/rgb_to_ycbcr_420_converter_unit.sv
hdl/rgbyc_checker.sv
tb/sv/rgb_to_ycbcr_420_converter_unit_test.sv
